### sv/io_control_override_handler_assert.svh
// Assertion macros shared by the override handler RTL.
`ifndef IO_CONTROL_OVERRIDE_HANDLER_ASSERT_SVH
`define IO_CONTROL_OVERRIDE_HANDLER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define IOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/ioc_pkg.sv
// Types, codes and constants of the I/O control override handler.
package ioc_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FORMAT      = 3'd1,
    ST_RANGE       = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_e;

  // control byte codes
  localparam logic [7:0] CTL_RETURN  = 8'd0;
  localparam logic [7:0] CTL_DEFAULT = 8'd1;
  localparam logic [7:0] CTL_FREEZE  = 8'd2;
  localparam logic [7:0] CTL_ADJUST  = 8'd3;

  // config register indexes
  localparam logic [2:0] CFG_AIR_ID       = 3'd0;
  localparam logic [2:0] CFG_PAIR_ID      = 3'd1;
  localparam logic [2:0] CFG_AIR_DEFAULT  = 3'd2;
  localparam logic [2:0] CFG_EGR_DEFAULT  = 3'd3;
  localparam logic [2:0] CFG_IAC_DEFAULT  = 3'd4;
  localparam logic [2:0] CFG_EGR_MASK     = 3'd5;
  localparam logic [2:0] CFG_IAC_MASK     = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] PCT_LIMIT      = 8'd100;
  localparam logic [7:0] LEN_ONE        = 8'd1;
  localparam logic [7:0] LEN_AIR_ADJUST = 8'd2;
  localparam logic [7:0] LEN_PAIR       = 8'd3;
  localparam logic [7:0] LEN_MASKED     = 8'd5;
  localparam logic [1:0] RSP_LEN_AIR    = 2'd2;
  localparam logic [1:0] RSP_LEN_PAIR   = 2'd3;

  typedef struct packed {
    logic [15:0] air_door_identifier;
    logic [15:0] egr_iac_identifier;
    logic [6:0]  air_default_position;
    logic [6:0]  egr_default_duty;
    logic [7:0]  iac_default_steps;
    logic [7:0]  egr_enable_mask;
    logic [7:0]  iac_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [15:0] identifier;
    logic [7:0]  control_byte;
    logic [7:0]  request_length;
    logic [7:0]  data_byte_one;
    logic [7:0]  data_byte_two;
    logic [7:0]  data_byte_three;
    logic [7:0]  data_byte_four;
    logic [7:0]  response_room;
  } req_t;

  typedef struct packed {
    logic [6:0] air_position;
    logic       air_overridden;
    logic       air_held;
    logic [6:0] egr_duty;
    logic [7:0] iac_steps;
    logic       egr_overridden;
    logic       iac_overridden;
    logic       egr_iac_held;
  } ovr_state_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] response_length;
    logic [7:0] echo_control;
    logic [7:0] reply_byte_one;
    logic [7:0] reply_byte_two;
  } rsp_t;

  // saturate a written percent value at the limit
  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    logic [6:0] r;
    r = ({1'b0, v} > PCT_LIMIT) ? PCT_LIMIT[6:0] : v;
    return r;
  endfunction

endpackage

### sv/ioc_decode.sv
// Request decode, checks and next override state for one request.
module ioc_decode (
  input  ioc_pkg::req_t       req_i,
  input  ioc_pkg::cfg_t       cfg_i,
  input  ioc_pkg::ovr_state_t state_i,
  output ioc_pkg::ovr_state_t state_o,
  output ioc_pkg::rsp_t       rsp_o
);
  import ioc_pkg::*;

  logic       is_air;
  logic       is_pair;
  logic       use_egr;
  logic       use_iac;
  logic [7:0] len;
  logic [1:0] need;
  status_e    status;
  ovr_state_t st;

  assign len     = req_i.request_length;
  assign is_air  = (req_i.identifier == cfg_i.air_door_identifier);
  assign is_pair = !is_air && (req_i.identifier == cfg_i.egr_iac_identifier);
  assign need    = is_air ? RSP_LEN_AIR : RSP_LEN_PAIR;

  always_comb begin
    st      = state_i;
    status  = ST_OK;
    use_egr = 1'b1;
    use_iac = 1'b1;
    if (len == 8'd0) begin
      status = ST_FORMAT;
    end else if (is_air) begin
      case (req_i.control_byte)
        CTL_RETURN, CTL_DEFAULT: begin
          if (len != LEN_ONE) begin
            status = ST_FORMAT;
          end else begin
            st.air_position   = cfg_i.air_default_position;
            st.air_overridden = (req_i.control_byte == CTL_DEFAULT);
            st.air_held       = 1'b0;
          end
        end
        CTL_FREEZE: begin
          if (len != LEN_ONE) begin
            status = ST_FORMAT;
          end else begin
            st.air_overridden = 1'b1;
            st.air_held       = 1'b1;
          end
        end
        CTL_ADJUST: begin
          if (len != LEN_AIR_ADJUST) begin
            status = ST_FORMAT;
          end else if (req_i.data_byte_one > PCT_LIMIT) begin
            status = ST_RANGE;
          end else begin
            st.air_position   = req_i.data_byte_one[6:0];
            st.air_overridden = 1'b1;
            st.air_held       = 1'b0;
          end
        end
        default: status = ST_UNSUPPORTED;
      endcase
    end else if (is_pair) begin
      case (req_i.control_byte)
        CTL_RETURN, CTL_DEFAULT: begin
          if (len == LEN_PAIR) begin
            use_egr = |(req_i.data_byte_one & cfg_i.egr_enable_mask);
            use_iac = |(req_i.data_byte_two & cfg_i.iac_enable_mask);
          end
          if (len != LEN_PAIR && len != LEN_ONE) begin
            status = ST_FORMAT;
          end else begin
            if (use_egr) begin
              st.egr_duty       = cfg_i.egr_default_duty;
              st.egr_overridden = (req_i.control_byte == CTL_DEFAULT);
            end
            if (use_iac) begin
              st.iac_steps      = cfg_i.iac_default_steps;
              st.iac_overridden = (req_i.control_byte == CTL_DEFAULT);
            end
            st.egr_iac_held = 1'b0;
          end
        end
        CTL_FREEZE: begin
          if (len != LEN_ONE && len != LEN_PAIR) begin
            status = ST_FORMAT;
          end else begin
            st.egr_iac_held = 1'b1;
          end
        end
        CTL_ADJUST: begin
          if (len == LEN_MASKED) begin
            use_egr = |(req_i.data_byte_three & cfg_i.egr_enable_mask);
            use_iac = |(req_i.data_byte_four & cfg_i.iac_enable_mask);
          end
          if (len != LEN_MASKED && len != LEN_PAIR) begin
            status = ST_FORMAT;
          end else if (use_egr && (req_i.data_byte_one > PCT_LIMIT)) begin
            status = ST_RANGE;
          end else begin
            if (use_egr) begin
              st.egr_duty       = req_i.data_byte_one[6:0];
              st.egr_overridden = 1'b1;
            end
            if (use_iac) begin
              st.iac_steps      = req_i.data_byte_two;
              st.iac_overridden = 1'b1;
            end
            st.egr_iac_held = 1'b0;
          end
        end
        default: status = ST_UNSUPPORTED;
      endcase
    end else begin
      status = ST_RANGE;
    end
  end

  // room is checked after the update: a short buffer keeps the new state
  always_comb begin
    rsp_o        = '0;
    rsp_o.status = status;
    if (status == ST_OK) begin
      if (req_i.response_room < {6'd0, need}) begin
        rsp_o.status = ST_TOO_LONG;
      end else begin
        rsp_o.response_length = need;
        rsp_o.echo_control    = req_i.control_byte;
        rsp_o.reply_byte_one  = is_air ? {1'b0, st.air_position} : {1'b0, st.egr_duty};
        rsp_o.reply_byte_two  = is_air ? 8'd0 : st.iac_steps;
      end
    end
  end

  assign state_o = st;

endmodule

### sv/io_control_override_handler.sv
// Top level of the I/O control override handler: registers, handshake, config.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  request  | in_valid_i / in_stall_o    | identifier_i .. response_room_i
//  result   | out_valid_o / out_stall_i  | status_o .. override_flags_o
//  config   | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the result is not stalled. A beat taken into
// the input register moves on to the result register and is offered from then on.
// The decode sits between them and updates the override state in the same cycle
// the result register loads, so the next request always sees the state left by
// the previous one.
// Reset clears handshake state, config to its reset values and the override
// state to zero. A stalled result holds the result register; a full input
// register then holds too and in_stall_o rises.
module io_control_override_handler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [ioc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ioc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request beat
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [15:0]                       identifier_i,
  input  logic [7:0]                        control_byte_i,
  input  logic [7:0]                        request_length_i,
  input  logic [7:0]                        data_byte_one_i,
  input  logic [7:0]                        data_byte_two_i,
  input  logic [7:0]                        data_byte_three_i,
  input  logic [7:0]                        data_byte_four_i,
  input  logic [7:0]                        response_room_i,
  // result beat
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ioc_pkg::status_e                  status_o,
  output logic [1:0]                        response_length_o,
  output logic [7:0]                        echo_control_o,
  output logic [7:0]                        reply_byte_one_o,
  output logic [7:0]                        reply_byte_two_o,
  output logic [6:0]                        air_position_now_o,
  output logic [6:0]                        egr_duty_now_o,
  output logic [7:0]                        iac_steps_now_o,
  output logic [4:0]                        override_flags_o
);
  import ioc_pkg::*;

  cfg_t       cfg_q;
  req_t       req_q;
  logic       req_valid_q;
  ovr_state_t state_q, state_d;
  rsp_t       rsp_d, rsp_q;
  ovr_state_t snap_q;           // state shown with the result beat
  logic       out_valid_q;

  logic out_free;
  logic advance;
  logic in_take;

  // result register can load when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // ---- config registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.air_door_identifier  <= 16'd0;
      cfg_q.egr_iac_identifier   <= 16'd1;
      cfg_q.air_default_position <= 7'd0;
      cfg_q.egr_default_duty     <= 7'd0;
      cfg_q.iac_default_steps    <= 8'd0;
      cfg_q.egr_enable_mask      <= 8'd1;
      cfg_q.iac_enable_mask      <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AIR_ID:      cfg_q.air_door_identifier  <= cfg_data_i;
        CFG_PAIR_ID:     cfg_q.egr_iac_identifier   <= cfg_data_i;
        CFG_AIR_DEFAULT: cfg_q.air_default_position <= clamp_pct(cfg_data_i[6:0]);
        CFG_EGR_DEFAULT: cfg_q.egr_default_duty     <= clamp_pct(cfg_data_i[6:0]);
        CFG_IAC_DEFAULT: cfg_q.iac_default_steps    <= cfg_data_i[7:0];
        CFG_EGR_MASK:    cfg_q.egr_enable_mask      <= cfg_data_i[7:0];
        CFG_IAC_MASK:    cfg_q.iac_enable_mask      <= cfg_data_i[7:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---- input register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_take) begin
      req_valid_q <= 1'b1;
    end else if (advance) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.identifier      <= identifier_i;
      req_q.control_byte    <= control_byte_i;
      req_q.request_length  <= request_length_i;
      req_q.data_byte_one   <= data_byte_one_i;
      req_q.data_byte_two   <= data_byte_two_i;
      req_q.data_byte_three <= data_byte_three_i;
      req_q.data_byte_four  <= data_byte_four_i;
      req_q.response_room   <= response_room_i;
    end
  end

  // ---- decode ----
  ioc_decode u_decode (
    .req_i   (req_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // ---- override state: commits when the request moves to the result ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q  <= rsp_d;
      snap_q <= state_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = rsp_q.status;
  assign response_length_o  = rsp_q.response_length;
  assign echo_control_o     = rsp_q.echo_control;
  assign reply_byte_one_o   = rsp_q.reply_byte_one;
  assign reply_byte_two_o   = rsp_q.reply_byte_two;
  assign air_position_now_o = snap_q.air_position;
  assign egr_duty_now_o     = snap_q.egr_duty;
  assign iac_steps_now_o    = snap_q.iac_steps;
  assign override_flags_o   = {snap_q.egr_iac_held, snap_q.iac_overridden,
                               snap_q.egr_overridden, snap_q.air_held,
                               snap_q.air_overridden};

  // ---- checks ----
`include "io_control_override_handler_assert.svh"

  `IOC_ASSERT(a_err_no_reply, out_valid_o && (status_o != ST_OK) |-> (response_length_o == 2'd0) && (echo_control_o == 8'd0), "error beat carries reply bytes")
  `IOC_ASSERT(a_ok_has_reply, out_valid_o && (status_o == ST_OK) |-> (response_length_o == RSP_LEN_AIR) || (response_length_o == RSP_LEN_PAIR), "ok beat without reply length")
  `IOC_ASSERT(a_pct_limit, ({1'b0, state_q.air_position} <= PCT_LIMIT) && ({1'b0, state_q.egr_duty} <= PCT_LIMIT), "percent state above limit")
  `IOC_ASSERT(a_frozen_owned, state_q.air_held |-> state_q.air_overridden, "air frozen but not under control")
  `IOC_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> req_valid_q, "input stalled with empty input register")

endmodule
